// ===== sv/sgcs_pkg.sv =====
// sgcs_pkg: types, register codes and reset constants for the
// sensor gated coil sequencer; no dependencies
`default_nettype none

package sgcs_pkg;

    // fixed field widths
    localparam int CH_MAX      = 4;
    localparam int CH_W        = 2;
    localparam int CUTOFF_W    = 10;
    localparam int SCALE_W     = 8;
    localparam int TICK_W      = 8;
    localparam int SENSE_W     = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int OUT_FIELD_W = CH_MAX + 2 + CH_W + SENSE_W + TICK_W;
    localparam int OUT_W       = ((OUT_FIELD_W + 7) / 8) * 8;

    // default module parameters
    localparam int NUM_CHANNELS_DEF = 4;
    localparam int SAMPLE_BITS_DEF  = 10;

    // register reset values
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 10'd500;
    localparam logic [SCALE_W-1:0]  SCALE_RESET  = 8'd16;
    localparam logic [TICK_W-1:0]   MIN_ON_RESET = 8'd0;
    localparam logic [TICK_W-1:0]   MAX_ON_RESET = 8'd70;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON  = 3'd6;

    typedef enum logic [1:0] {
        PH_ARMING    = 2'd0,
        PH_SCANNING  = 2'd1,
        PH_MEASURING = 2'd2,
        PH_FIRING    = 2'd3
    } t_phase;

    typedef struct packed {
        logic [CH_MAX-1:0][CUTOFF_W-1:0] cutoff;
        logic [SCALE_W-1:0]              scale;
        logic [TICK_W-1:0]               min_on;
        logic [TICK_W-1:0]               max_on;
    } t_cfg;

    typedef struct packed {
        t_phase             mode;
        logic [CH_W-1:0]    channel;
        logic [SENSE_W-1:0] elapsed;
        logic [TICK_W-1:0]  remaining;
        logic [SENSE_W-1:0] last_sense;
        logic [TICK_W-1:0]  last_pulse;
    } t_state;

    typedef struct packed {
        logic [CH_MAX-1:0]  coil_drive;
        logic [1:0]         phase;
        logic [CH_W-1:0]    active_channel;
        logic [SENSE_W-1:0] sense_ticks;
        logic [TICK_W-1:0]  pulse_ticks;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/sgcs_step.sv =====
// sgcs_step: one tick of the sequencer, next state and result from the
// current state, the registered samples and the configuration; uses sgcs_pkg
`default_nettype none

module sgcs_step
    import sgcs_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  wire t_state                            i_state,
    input  wire t_cfg                              i_cfg,
    input  wire logic [CH_MAX-1:0][SAMPLE_BITS-1:0] i_sample,
    output t_state                                 o_state,
    output t_result                                o_result
);

    localparam int CMP_W  = (SAMPLE_BITS > CUTOFF_W) ? SAMPLE_BITS : CUTOFF_W;
    localparam int PROD_W = SENSE_W + SCALE_W;
    localparam int FRAC_W = 4;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    logic [CH_MAX-1:0]       w_below;
    logic [PROD_W-1:0]       w_prod;
    logic [PROD_W-FRAC_W-1:0] w_pulse_raw;
    logic [PROD_W-FRAC_W-1:0] w_pulse_lo;
    logic [TICK_W-1:0]       w_pulse;
    logic [CH_W-1:0]         w_next_ch;

    // per channel trigger flags, unused channels never trigger
    always_comb begin
        for (int c = 0; c < CH_MAX; c++) begin
            w_below[c] = (c < NUM_CHANNELS) &&
                         (CMP_W'(i_sample[c]) < CMP_W'(i_cfg.cutoff[c]));
        end
    end

    // pulse length: scaled count, raised to min then lowered to max
    always_comb begin
        w_prod      = PROD_W'(i_state.elapsed) * PROD_W'(i_cfg.scale);
        w_pulse_raw = w_prod[PROD_W-1:FRAC_W];
        w_pulse_lo  = (w_pulse_raw < (PROD_W-FRAC_W)'(i_cfg.min_on)) ?
                      (PROD_W-FRAC_W)'(i_cfg.min_on) : w_pulse_raw;
        w_pulse     = (w_pulse_lo > (PROD_W-FRAC_W)'(i_cfg.max_on)) ?
                      i_cfg.max_on : w_pulse_lo[TICK_W-1:0];
    end

    assign w_next_ch = (i_state.channel >= LAST_CH) ? '0 : i_state.channel + 1'b1;

    // next state
    always_comb begin
        logic            found;
        logic [CH_W-1:0] found_ch;
        found    = 1'b0;
        found_ch = '0;
        o_state  = i_state;
        unique case (i_state.mode)
            PH_ARMING: begin
                if (w_below == '0) begin
                    o_state.mode    = PH_SCANNING;
                    o_state.channel = '0;
                end
            end
            PH_SCANNING: begin
                // first triggered channel at or above the scan position
                for (int c = 0; c < CH_MAX; c++) begin
                    if (!found && (c >= int'(i_state.channel)) && w_below[c]) begin
                        found    = 1'b1;
                        found_ch = CH_W'(c);
                    end
                end
                if (found) begin
                    o_state.mode    = PH_MEASURING;
                    o_state.channel = found_ch;
                    o_state.elapsed = '0;
                end else begin
                    o_state.channel = '0;
                end
            end
            PH_MEASURING: begin
                if (w_below[i_state.channel] &&
                    (i_state.elapsed <= SENSE_W'(i_cfg.max_on))) begin
                    o_state.elapsed = i_state.elapsed + 1'b1;
                end else begin
                    o_state.last_sense = i_state.elapsed;
                    o_state.last_pulse = w_pulse;
                    if (w_pulse == '0) begin
                        o_state.mode    = PH_SCANNING;
                        o_state.channel = w_next_ch;
                    end else begin
                        o_state.mode      = PH_FIRING;
                        o_state.remaining = w_pulse;
                    end
                end
            end
            PH_FIRING: begin
                if (i_state.remaining <= TICK_W'(1)) begin
                    o_state.remaining = '0;
                    o_state.mode      = PH_SCANNING;
                    o_state.channel   = w_next_ch;
                end else begin
                    o_state.remaining = i_state.remaining - 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

    // result fields, coil driven whenever the tick leaves the block firing
    always_comb begin
        o_result.coil_drive     = (o_state.mode == PH_FIRING) ?
                                  (CH_MAX'(1) << o_state.channel) : '0;
        o_result.phase          = o_state.mode;
        o_result.active_channel = o_state.channel;
        o_result.sense_ticks    = o_state.last_sense;
        o_result.pulse_ticks    = o_state.last_pulse;
    end

endmodule

`default_nettype wire

// ===== sv/sensor_gated_coil_sequencer.sv =====
// sensor_gated_coil_sequencer: top level with input register, config
// registers, sequencer state and result register; uses sgcs_pkg, sgcs_step
`default_nettype none

// channel    direction  handshake                     payload
// s_axis     in         s_axis_tvalid/s_axis_tready   four samples per tick
// m_axis     out        m_axis_tvalid/m_axis_tready   one status result per tick
// cfg        in         i_cfg_we                      register index and value
//
// one request accepted per clock while s_axis_tready is high; a request moves
// through the input register, then the result register, set by the single step unit
// synchronous active low reset restores register defaults and arming state
// a stalled result holds in the result register while the next request waits
// in the input register; s_axis_tready drops only when both are full

module sensor_gated_coil_sequencer
    import sgcs_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3, zero fill
    input  wire logic [((CH_MAX*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // coil_drive, phase, active_channel, sense_ticks, pulse_ticks, zero fill
    output logic [OUT_W-1:0]           m_axis_tdata
);

    logic                               r_in_valid;
    logic [CH_MAX-1:0][SAMPLE_BITS-1:0] r_sample;
    t_cfg                               r_cfg;
    t_state                             r_state;
    logic                               r_out_valid;
    t_result                            r_out;

    t_state  n_state;
    t_result w_result;
    logic    w_advance;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            for (int c = 0; c < CH_MAX; c++) begin
                r_sample[c] <= s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CH_MAX; c++) begin
                r_cfg.cutoff[c] <= CUTOFF_RESET;
            end
            r_cfg.scale  <= SCALE_RESET;
            r_cfg.min_on <= MIN_ON_RESET;
            r_cfg.max_on <= MAX_ON_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CUTOFF0: r_cfg.cutoff[0] <= i_cfg_data;
                CFG_CUTOFF1: r_cfg.cutoff[1] <= i_cfg_data;
                CFG_CUTOFF2: r_cfg.cutoff[2] <= i_cfg_data;
                CFG_CUTOFF3: r_cfg.cutoff[3] <= i_cfg_data;
                CFG_SCALE:   r_cfg.scale     <= i_cfg_data[SCALE_W-1:0];
                CFG_MIN_ON:  r_cfg.min_on    <= i_cfg_data[TICK_W-1:0];
                CFG_MAX_ON:  r_cfg.max_on    <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // tick evaluation
    sgcs_step #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_sample (r_sample),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // sequencer state, updated as each tick moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: PH_ARMING, default: '0};
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_W - OUT_FIELD_W)'(0),
                            r_out.pulse_ticks,
                            r_out.sense_ticks,
                            r_out.active_channel,
                            r_out.phase,
                            r_out.coil_drive};

endmodule

`default_nettype wire
